FILE: hw/rtl/lobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared sizes, codes and types of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    // book geometry; slots of a book wrap around a head pointer, so the
    // depth has to stay a power of two
    localparam int BOOK_DEPTH      = 32;
    localparam int NUM_INSTRUMENTS = 5;
    localparam int NUM_BOOKS       = 2 * NUM_INSTRUMENTS;
    localparam int MAX_RESULTS     = 32;
    localparam int SLOT_W          = $clog2(BOOK_DEPTH);
    localparam int CNT_W           = $clog2(BOOK_DEPTH + 1);
    localparam int BOOK_W          = $clog2(NUM_BOOKS);
    localparam int ADDR_W          = BOOK_W + SLOT_W;
    localparam int MEM_DEPTH       = NUM_BOOKS * BOOK_DEPTH;
    localparam int NRES_W          = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] MIN_QTY_RESET = 16'd10;
    localparam logic [15:0] MAX_QTY_RESET = 16'd1000;

    localparam logic [7:0] CFG_MIN_QTY = 8'd0;
    localparam logic [7:0] CFG_MAX_QTY = 8'd1;

    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_REJ     = 2'd1;
    localparam logic [1:0] ST_FILLED  = 2'd2;
    localparam logic [1:0] ST_PARTIAL = 2'd3;

    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_INSTR = 3'd1;
    localparam logic [2:0] RSN_SIDE  = 3'd2;
    localparam logic [2:0] RSN_PRICE = 3'd3;
    localparam logic [2:0] RSN_QTY   = 3'd4;
    localparam logic [2:0] RSN_FULL  = 3'd5;

    typedef struct packed {
        logic [15:0]        num;
        logic [15:0]        tag;
        logic [2:0]         instr;
        logic [1:0]         side;
        logic [15:0]        qty;
        logic signed [15:0] price;
        logic [2:0]         reason;
    } order_t;

    typedef struct packed {
        logic [15:0]        number;
        logic [15:0]        tag;
        logic [15:0]        qty;
        logic signed [15:0] price;
    } entry_t;

    typedef struct packed {
        logic [15:0]        inum;
        logic [15:0]        itag;
        logic [15:0]        rnum;
        logic [15:0]        rtag;
        logic [2:0]         instr;
        logic [1:0]         side;
        logic [15:0]        qty;
        logic signed [15:0] price;
        logic [1:0]         ist;
        logic [1:0]         rst;
        logic [2:0]         reason;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lobm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_front
// Takes orders, numbers them and checks their fields against the limits.
// ----------------------------------------------------------------------------
module lobm_front import lobm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // client_tag, instrument, side, quantity, limit_price, zero pad
    input  wire logic [55:0] s_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             push_valid,
    input  wire logic        push_ready,
    output order_t           push_data
);

    logic [15:0] min_qty_reg;
    logic [15:0] max_qty_reg;
    logic [15:0] counter_reg;

    logic [15:0]        qty;
    logic signed [15:0] price;
    logic [31:0]        prod;
    logic [12:0]        quot;
    logic [15:0]        rem10;
    logic [2:0]         reason;

    assign qty   = s_tdata[36:21];
    assign price = s_tdata[52:37];

    // divide by ten through a reciprocal, exact over 16 bits
    assign prod  = 32'(qty) * 32'd52429;
    assign quot  = prod[31:19];
    assign rem10 = qty - 16'(32'(quot) * 32'd10);

    always_comb begin
        if (32'(s_tdata[18:16]) >= NUM_INSTRUMENTS) begin
            reason = RSN_INSTR;
        end else if (s_tdata[20:19] != SIDE_BUY && s_tdata[20:19] != SIDE_SELL) begin
            reason = RSN_SIDE;
        end else if (price[15] || price == 16'sd0) begin
            reason = RSN_PRICE;
        end else if (rem10 != 16'd0 || qty > max_qty_reg || qty < min_qty_reg) begin
            reason = RSN_QTY;
        end else begin
            reason = RSN_NONE;
        end
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign cfg_ready  = 1'b1;

    always_comb begin
        push_data.num    = counter_reg + 16'd1;
        push_data.tag    = s_tdata[15:0];
        push_data.instr  = s_tdata[18:16];
        push_data.side   = s_tdata[20:19];
        push_data.qty    = qty;
        push_data.price  = price;
        push_data.reason = reason;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_qty_reg <= MIN_QTY_RESET;
            max_qty_reg <= MAX_QTY_RESET;
            counter_reg <= 16'd0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_MIN_QTY) begin
                    min_qty_reg <= cfg_data;
                end else if (cfg_index == CFG_MAX_QTY) begin
                    max_qty_reg <= cfg_data;
                end
            end
            if (s_tvalid && push_ready) begin
                counter_reg <= counter_reg + 16'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/lobm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_queue
// Short queue of checked orders between the front and the matching engine.
// ----------------------------------------------------------------------------
module lobm_queue import lobm_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_valid,
    output logic        wr_ready,
    input  wire order_t wr_data,
    output logic        rd_valid,
    input  wire logic   rd_ready,
    output order_t      rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    order_t                         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]               wptr_reg;
    logic [PTR_W-1:0]               rptr_reg;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] fill_reg;
    logic                           do_wr;
    logic                           do_rd;

    assign wr_ready = 32'(fill_reg) < QUEUE_DEPTH;
    assign rd_valid = fill_reg != '0;
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= PTR_W'(32'(wptr_reg) + 1 == QUEUE_DEPTH ? 0 : 32'(wptr_reg) + 1);
            end
            if (do_rd) begin
                rptr_reg <= PTR_W'(32'(rptr_reg) + 1 == QUEUE_DEPTH ? 0 : 32'(rptr_reg) + 1);
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/lobm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_back
// Matching engine: walks the opposite book, reports trades and rests the
// remainder by a backward insertion sweep through the book memory.
// ----------------------------------------------------------------------------
module lobm_back import lobm_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire order_t q_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MREQ, S_MCHK, S_MEND, S_IINIT, S_IREQ, S_ICMP
    } state_t;

    state_t            state_reg;
    order_t            ord_reg;
    logic [BOOK_W-1:0] bk_reg;
    logic [15:0]       rem_reg;
    logic [NRES_W-1:0] nres_reg;
    logic [CNT_W-1:0]  j_reg;
    result_t           pend_reg;
    logic              pend_v_reg;
    result_t           out_reg;
    logic              out_v_reg;
    logic [CNT_W-1:0]  cnt_reg  [NUM_BOOKS];
    logic [SLOT_W-1:0] head_reg [NUM_BOOKS];

    entry_t            mem [MEM_DEPTH];
    entry_t            rdata_reg;

    logic              re, we;
    logic [ADDR_W-1:0] raddr, waddr;
    entry_t            wdata;

    logic [CNT_W-1:0]  cnt_cur;
    logic [SLOT_W-1:0] head_cur;
    logic              out_free;
    logic              out_load;
    logic [BOOK_W-1:0] own_bk, opp_bk;
    logic              is_buy;
    logic              go_match;
    logic              crosses;
    logic              advance;
    logic              worse;
    logic [15:0]       fill, rem_after, rq_after;
    logic [SLOT_W-1:0] jm1_slot;
    entry_t            new_entry;
    result_t           trade, new_rep, rej_rep, last_rep;

    assign cnt_cur   = cnt_reg[bk_reg];
    assign head_cur  = head_reg[bk_reg];
    assign out_free  = !out_v_reg || out_ready;
    assign is_buy    = ord_reg.side == SIDE_BUY;
    assign own_bk    = BOOK_W'({ord_reg.instr, ord_reg.side == SIDE_SELL});
    assign opp_bk    = BOOK_W'({ord_reg.instr, ord_reg.side != SIDE_SELL});
    assign go_match  = rem_reg != 16'd0 && cnt_cur != '0 && 32'(nres_reg) < MAX_RESULTS;
    assign crosses   = is_buy ? (rdata_reg.price <= ord_reg.price)
                              : (rdata_reg.price >= ord_reg.price);
    assign advance   = crosses && (!pend_v_reg || out_free);
    assign worse     = is_buy ? (rdata_reg.price < ord_reg.price)
                              : (rdata_reg.price > ord_reg.price);
    assign fill      = rem_reg < rdata_reg.qty ? rem_reg : rdata_reg.qty;
    assign rem_after = rem_reg - fill;
    assign rq_after  = rdata_reg.qty - fill;
    assign jm1_slot  = SLOT_W'(j_reg - 1'b1);

    // cycles in which the output register takes a new report
    assign out_load  = (state_reg == S_CHECK && out_free
                        && (ord_reg.reason != RSN_NONE || 32'(cnt_cur) >= BOOK_DEPTH))
                    || (state_reg == S_MCHK && advance && pend_v_reg)
                    || (state_reg == S_MEND && out_free);

    always_comb begin
        new_entry.number = ord_reg.num;
        new_entry.tag    = ord_reg.tag;
        new_entry.qty    = rem_reg;
        new_entry.price  = ord_reg.price;

        trade.inum   = ord_reg.num;
        trade.itag   = ord_reg.tag;
        trade.rnum   = rdata_reg.number;
        trade.rtag   = rdata_reg.tag;
        trade.instr  = ord_reg.instr;
        trade.side   = ord_reg.side;
        trade.qty    = fill;
        trade.price  = rdata_reg.price;
        trade.ist    = rem_after == 16'd0 ? ST_FILLED : ST_PARTIAL;
        trade.rst    = rq_after == 16'd0 ? ST_FILLED : ST_PARTIAL;
        trade.reason = RSN_NONE;
        trade.last   = 1'b0;

        new_rep        = trade;
        new_rep.rnum   = 16'd0;
        new_rep.rtag   = 16'd0;
        new_rep.qty    = ord_reg.qty;
        new_rep.price  = ord_reg.price;
        new_rep.ist    = ST_NEW;
        new_rep.rst    = ST_NEW;
        new_rep.last   = 1'b1;

        rej_rep        = new_rep;
        rej_rep.ist    = ST_REJ;
        rej_rep.reason = ord_reg.reason != RSN_NONE ? ord_reg.reason : RSN_FULL;

        last_rep       = pend_reg;
        last_rep.last  = 1'b1;
    end

    // memory port control
    always_comb begin
        re    = 1'b0;
        we    = 1'b0;
        raddr = {bk_reg, head_cur};
        waddr = {bk_reg, head_cur};
        wdata = new_entry;
        unique case (state_reg)
            S_MREQ: begin
                re = go_match;
            end
            S_MCHK: begin
                if (advance && rq_after != 16'd0) begin
                    we        = 1'b1;
                    wdata     = rdata_reg;
                    wdata.qty = rq_after;
                end
            end
            S_IREQ: begin
                if (j_reg == '0) begin
                    we = 1'b1;
                end else begin
                    re    = 1'b1;
                    raddr = {bk_reg, head_cur + jm1_slot};
                end
            end
            S_ICMP: begin
                we    = 1'b1;
                waddr = {bk_reg, head_cur + SLOT_W'(j_reg)};
                if (worse) begin
                    wdata = rdata_reg;
                end
            end
            default: begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign q_ready   = state_reg == S_IDLE;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            bk_reg     <= '0;
            for (int i = 0; i < NUM_BOOKS; i++) begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                out_v_reg <= 1'b1;
            end else if (out_ready) begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        ord_reg   <= q_data;
                        bk_reg    <= BOOK_W'({q_data.instr, q_data.side == SIDE_SELL});
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (ord_reg.reason != RSN_NONE || 32'(cnt_cur) >= BOOK_DEPTH) begin
                        if (out_free) begin
                            out_reg   <= rej_rep;
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        bk_reg    <= opp_bk;
                        rem_reg   <= ord_reg.qty;
                        nres_reg  <= '0;
                        state_reg <= S_MREQ;
                    end
                end
                S_MREQ: begin
                    state_reg <= go_match ? S_MCHK : S_MEND;
                end
                S_MCHK: begin
                    if (!crosses) begin
                        state_reg <= S_MEND;
                    end else if (advance) begin
                        // previous trade goes out once the next one is known
                        if (pend_v_reg) begin
                            out_reg <= pend_reg;
                        end
                        pend_reg   <= trade;
                        pend_v_reg <= 1'b1;
                        rem_reg    <= rem_after;
                        nres_reg   <= nres_reg + 1'b1;
                        if (rq_after == 16'd0) begin
                            head_reg[bk_reg] <= head_cur + 1'b1;
                            cnt_reg[bk_reg]  <= cnt_cur - 1'b1;
                        end
                        state_reg <= S_MREQ;
                    end
                end
                S_MEND: begin
                    if (out_free) begin
                        if (pend_v_reg) begin
                            out_reg <= last_rep;
                        end else begin
                            out_reg <= new_rep;
                        end
                        pend_v_reg <= 1'b0;
                        if (rem_reg != 16'd0) begin
                            bk_reg    <= own_bk;
                            state_reg <= S_IINIT;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_IINIT: begin
                    j_reg     <= cnt_cur;
                    state_reg <= S_IREQ;
                end
                S_IREQ: begin
                    if (j_reg == '0) begin
                        cnt_reg[bk_reg] <= cnt_cur + 1'b1;
                        state_reg       <= S_IDLE;
                    end else begin
                        state_reg <= S_ICMP;
                    end
                end
                S_ICMP: begin
                    if (worse) begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= S_IREQ;
                    end else begin
                        cnt_reg[bk_reg] <= cnt_cur + 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a rejected order with a bad instrument points past the last book
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(bk_reg) < NUM_BOOKS |-> 32'(cnt_cur) <= BOOK_DEPTH)
        else $error("book count above depth");
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pend_v_reg)
        else $error("held trade left behind");
    a_nres_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MCHK |-> 32'(nres_reg) < MAX_RESULTS)
        else $error("trade limit overrun");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-priority order book for five instruments with per-order reports.
// ----------------------------------------------------------------------------
// Orders enter on the s_ stream, one per transfer; reports leave on the m_
// stream, one or more per order, the final one with m_tlast high.
// The cfg channel writes min_quantity (index 0) and max_quantity (index 1)
// and is always ready; write it only while the block is idle.
// The front checks and numbers an order in its accept cycle and places it in
// a two-entry queue, so orders are taken while the engine is busy.
// The engine takes one order at a time from the queue:
//   take and check: S_IDLE, then S_CHECK, which loads any reject report
//   match: S_MREQ and S_MCHK per resting order met, then S_MEND ends the walk
//   resting a remainder: S_IINIT, then S_IREQ and S_ICMP per entry that moves down
// Reset empties the books, clears the order counter and sets the limits (10 and 1000).
// A stalled m_ side holds the engine at its next report; the queue then fills
// and s_tready drops.
// ----------------------------------------------------------------------------
module limit_order_book_matcher import lobm_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // client_tag, instrument, side, quantity, limit_price, zero pad
    input  wire logic [55:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // incoming_number, incoming_tag, resting_number, resting_tag,
    // report_instrument, report_side, fill_quantity, fill_price,
    // incoming_status, resting_status, reject_reason, zero pad
    output logic [111:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    logic    push_valid, push_ready;
    order_t  push_data;
    logic    pop_valid, pop_ready;
    order_t  pop_data;
    result_t res;

    lobm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lobm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    lobm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {4'b0, res.reason, res.rst, res.ist, res.price, res.qty,
                      res.side, res.instr, res.rtag, res.rnum, res.itag, res.inum};
    assign m_tlast = res.last;

endmodule
`default_nettype wire

FILE: sim/lobm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_checker
// Watches the order, report and cfg channels of the order book matcher.
// Keeps its own copy of the books and limits, works out the reports of each
// accepted order and compares every report transfer with the oldest one due.
// ----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [55:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [111:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output int                fail_count,
    output int                pending
);

    entry_t      books [NUM_BOOKS][BOOK_DEPTH];
    int          book_len [NUM_BOOKS];
    logic [15:0] order_seq;
    logic [15:0] min_qty;
    logic [15:0] max_qty;
    result_t     reports_due [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic book_order(input logic [55:0] d);
        logic [15:0]        tag;
        logic [15:0]        qty;
        logic [2:0]         ins;
        logic [1:0]         sd;
        logic signed [15:0] px;
        logic [2:0]         why;
        int                 own;
        int                 opp;
        int                 rem;
        int                 n;
        int                 pos;
        int                 fill;
        bit                 crosses;
        result_t            r;
        tag = d[15:0];
        ins = d[18:16];
        sd  = d[20:19];
        qty = d[36:21];
        px  = d[52:37];
        order_seq = order_seq + 16'd1;
        why = RSN_NONE;
        own = ins * 2 + (sd == SIDE_SELL ? 1 : 0);
        opp = ins * 2 + (sd == SIDE_SELL ? 0 : 1);
        if (ins >= NUM_INSTRUMENTS)
            why = RSN_INSTR;
        else if (sd != SIDE_BUY && sd != SIDE_SELL)
            why = RSN_SIDE;
        else if (px <= 16'sd0)
            why = RSN_PRICE;
        else if (qty % 10 != 0 || qty > max_qty || qty < min_qty)
            why = RSN_QTY;
        else if (book_len[own] >= BOOK_DEPTH)
            why = RSN_FULL;
        r = '0;
        r.inum  = order_seq;
        r.itag  = tag;
        r.instr = ins;
        r.side  = sd;
        if (why != RSN_NONE) begin
            r.qty    = qty;
            r.price  = px;
            r.ist    = ST_REJ;
            r.reason = why;
            r.last   = 1'b1;
            reports_due = {reports_due, r};
            return;
        end
        rem = qty;
        n   = 0;
        while (rem > 0 && book_len[opp] > 0 && n < MAX_RESULTS) begin
            crosses = (sd == SIDE_BUY) ? (books[opp][0].price <= px)
                                       : (books[opp][0].price >= px);
            if (!crosses)
                break;
            fill = (rem < books[opp][0].qty) ? rem : books[opp][0].qty;
            rem  = rem - fill;
            books[opp][0].qty = 16'(books[opp][0].qty - fill);
            r.rnum  = books[opp][0].number;
            r.rtag  = books[opp][0].tag;
            r.qty   = 16'(fill);
            r.price = books[opp][0].price;
            r.ist   = (rem == 0) ? ST_FILLED : ST_PARTIAL;
            r.rst   = (books[opp][0].qty == 0) ? ST_FILLED : ST_PARTIAL;
            r.last  = 1'b0;
            reports_due = {reports_due, r};
            n++;
            if (books[opp][0].qty == 0) begin
                for (int i = 0; i < book_len[opp] - 1; i++)
                    books[opp][i] = books[opp][i + 1];
                book_len[opp]--;
            end
        end
        if (n == 0) begin
            r.qty   = qty;
            r.price = px;
            r.ist   = ST_NEW;
            r.last  = 1'b1;
            reports_due = {reports_due, r};
        end else begin
            reports_due[reports_due.size() - 1].last = 1'b1;
        end
        if (rem > 0) begin
            pos = 0;
            while (pos < book_len[own]) begin
                if (sd == SIDE_BUY ? (books[own][pos].price < px) : (books[own][pos].price > px))
                    break;
                pos++;
            end
            for (int i = book_len[own]; i > pos; i--)
                books[own][i] = books[own][i - 1];
            books[own][pos].number = order_seq;
            books[own][pos].tag    = tag;
            books[own][pos].qty    = 16'(rem);
            books[own][pos].price  = px;
            book_len[own]++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            for (int b = 0; b < NUM_BOOKS; b++)
                book_len[b] = 0;
            order_seq = '0;
            min_qty   = MIN_QTY_RESET;
            max_qty   = MAX_QTY_RESET;
            reports_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.inum   = m_tdata[15:0];
                got.itag   = m_tdata[31:16];
                got.rnum   = m_tdata[47:32];
                got.rtag   = m_tdata[63:48];
                got.instr  = m_tdata[66:64];
                got.side   = m_tdata[68:67];
                got.qty    = m_tdata[84:69];
                got.price  = m_tdata[100:85];
                got.ist    = m_tdata[102:101];
                got.rst    = m_tdata[104:103];
                got.reason = m_tdata[107:105];
                got.last   = m_tlast;
                if (reports_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected report transfer: %p", got);
                end else begin
                    want = reports_due.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("report mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
            // an order taken at this edge still sees the old limits
            if (s_tvalid && s_tready)
                book_order(s_tdata);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MIN_QTY)
                    min_qty = cfg_data;
                else if (cfg_index == CFG_MAX_QTY)
                    max_qty = cfg_data;
            end
        end
        pending = reports_due.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Order stream test of the limit order book matcher.
// Directed orders hit every reject reason, partial and multi-level fills and
// the trade limit; random orders then run under several quantity limits with
// both stream sides stalling at changing rates.
// ----------------------------------------------------------------------------
module tb_top import lobm_pkg::*;;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [15:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           cycles;
    int           cur_min;
    int           cur_max;

    limit_order_book_matcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lobm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_order(input logic [15:0] tag, input logic [2:0] ins,
                              input logic [1:0] sd, input logic [15:0] qty,
                              input logic [15:0] px);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, px, qty, sd, ins, tag};
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every report is out, then let the engine settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_limits(input int lo, input int hi);
        drain();
        write_reg(CFG_MIN_QTY, lo[15:0]);
        write_reg(CFG_MAX_QTY, hi[15:0]);
        cur_min = lo;
        cur_max = hi;
    endtask

    task automatic random_order();
        int          pick;
        int          lo;
        int          hi;
        logic [1:0]  sd;
        logic [15:0] qty;
        logic [15:0] px;
        pick = $urandom_range(99);
        sd   = $urandom_range(1) ? SIDE_SELL : SIDE_BUY;
        lo   = (cur_min + 9) / 10;
        hi   = cur_max / 10;
        if (lo > hi)
            qty = 16'(10 * $urandom_range(120));
        else begin
            if ($urandom_range(99) < 85 && hi > lo + 20)
                hi = lo + 20;
            qty = 16'(10 * $urandom_range(hi, lo));
        end
        px = (sd == SIDE_BUY) ? 16'(95 + $urandom_range(10)) : 16'(100 + $urandom_range(10));
        if (pick < 80)
            send_order(16'($urandom), 3'($urandom_range(4)), sd, qty, px);
        else if (pick < 90)
            send_order(16'($urandom), 3'($urandom), 2'($urandom), 16'($urandom),
                       16'($urandom));
        else begin
            // one bad field in an otherwise sane order
            case ($urandom_range(3))
                0: send_order(16'($urandom), 3'(5 + $urandom_range(2)), sd, qty, px);
                1: send_order(16'($urandom), 3'($urandom_range(4)),
                              $urandom_range(1) ? 2'd0 : 2'd3, qty, px);
                2: send_order(16'($urandom), 3'($urandom_range(4)), sd, qty,
                              16'($urandom_range(1)) << 15);
                default: send_order(16'($urandom), 3'($urandom_range(4)), sd,
                                    qty + 16'd5, px);
            endcase
        end
    endtask

    initial begin
        int sent;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 22;
        recv_idle_pct = 80;
        cur_min       = 10;
        cur_max       = 1000;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reject reasons in check order
        send_order(16'h0000, 3'd7, SIDE_BUY, 16'd10, 16'd100);
        send_order(16'hffff, 3'd5, 2'd0, 16'd15, 16'd0);
        send_order(16'h1234, 3'd0, 2'd0, 16'd10, 16'd100);
        send_order(16'h1235, 3'd0, 2'd3, 16'd10, 16'd100);
        send_order(16'h1236, 3'd0, SIDE_BUY, 16'd10, 16'd0);
        send_order(16'h1237, 3'd0, SIDE_SELL, 16'd10, 16'h8000);
        send_order(16'h1238, 3'd0, SIDE_BUY, 16'd15, 16'd100);
        send_order(16'h1239, 3'd0, SIDE_BUY, 16'd1010, 16'd100);
        send_order(16'h123a, 3'd0, SIDE_BUY, 16'd0, 16'd100);
        send_order(16'h123b, 3'd0, SIDE_BUY, 16'hffff, 16'h7fff);
        // top price rests, then a large sell takes it and rests the rest at 1
        send_order(16'hffff, 3'd0, SIDE_BUY, 16'd10, 16'h7fff);
        send_order(16'h0001, 3'd0, SIDE_SELL, 16'd1000, 16'd1);
        // partial fill of a resting order
        send_order(16'h0002, 3'd1, SIDE_BUY, 16'd20, 16'd50);
        send_order(16'h0003, 3'd1, SIDE_SELL, 16'd10, 16'd50);
        send_order(16'h0004, 3'd1, SIDE_SELL, 16'd10, 16'd40);
        // price levels and arrival order
        send_order(16'h0005, 3'd2, SIDE_SELL, 16'd10, 16'd60);
        send_order(16'h0006, 3'd2, SIDE_SELL, 16'd10, 16'd55);
        send_order(16'h0007, 3'd2, SIDE_SELL, 16'd20, 16'd55);
        send_order(16'h0008, 3'd2, SIDE_BUY, 16'd50, 16'd60);
        send_order(16'h0009, 3'd4, SIDE_SELL, 16'd30, 16'd70);
        send_order(16'h000a, 3'd4, SIDE_BUY, 16'd10, 16'd69);

        // fill one book to the top, then sweep it up to the trade limit
        for (int i = 0; i < BOOK_DEPTH + 1; i++)
            send_order(16'($urandom), 3'd3, SIDE_SELL, 16'd10, 16'(200 + $urandom_range(3)));
        send_order(16'($urandom), 3'd3, SIDE_BUY, 16'd1000, 16'd300);

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: set_limits(0, 65535);
                2: set_limits(500, 100);
                3: set_limits(10, 1000);
                default: ;
            endcase
            for (int k = 0; k < 101; k++) begin
                if (sent < 135) begin
                    send_idle_pct = 22;
                    recv_idle_pct = 80;
                end else if (sent < 270) begin
                    send_idle_pct = 80;
                    recv_idle_pct = 22;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_order();
                sent++;
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_front.sv
hw/rtl/lobm_queue.sv
hw/rtl/lobm_back.sv
hw/rtl/limit_order_book_matcher.sv
sim/lobm_checker.sv
sim/tb_top.sv
